FILE: hdl/hra_pkg.sv
// hashed result accumulator: shared types and constants
// no dependencies
package hra_pkg;

  localparam int KEY_W   = 31;
  localparam int SCORE_W = 32;
  localparam int CNT_W   = 24;
  localparam int IDX_W   = 12;
  localparam int LIM_W   = 13;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_PROBE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd4096;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic clr_step;   // start clearing pass step
    logic head_rd;    // read bucket head
    logic ent_rd;     // read entry at current pointer
    logic follow;     // pointer takes next link
    logic upd;        // write merged entry back
    logic ins;        // write new entry and relink bucket
    logic rd_idx;     // pointer takes read index
    logic fin_hit;    // result from entry
    logic fin_miss;   // result all zero except flags
    logic fin_drop;   // dropped result
    logic out_take;   // result handed over
  } hra_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic head_valid;
    logic key_match;
    logic next_valid;
    logic ptr_ok;      // pointer below entry count
    logic full;
    logic ridx_ok;
    logic clr_done;
    logic out_valid;
  } hra_sts_t;

  function automatic logic [SCORE_W-1:0] sat_score(input logic [SCORE_W-1:0] a,
                                                   input logic [SCORE_W-1:0] b);
    logic [SCORE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SCORE_W] ? {SCORE_W{1'b1}} : s[SCORE_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

FILE: hdl/hashed_result_accumulator_core.sv
// hashed result accumulator, top level: config register, sequencer, datapath
// depends on hra_pkg, hra_ctrl, hra_dp
//
// Usage:
//   Input items (operation, doc_key, scores, counts, read_index) arrive on
//   in_valid/in_stall; one result item per input leaves on out_valid/out_stall.
//   Each lookup walks its bucket chain, one entry memory read per link:
//   an add or probe reads the bucket head, then entries until the key
//   matches or the chain ends; a read fetches the entry at read_index,
//   or reports a miss for an index out of range.
//   The head and entry memory reads are registered.
//   Results sit in an output register; while the receiver stalls it holds,
//   and the next item is taken once that register is free or leaving.
//   After reset a clearing pass writes every bucket head, one per cycle,
//   during which no item is taken; the APB port (entry_limit at address 0)
//   works throughout.
module hashed_result_accumulator_core import hra_pkg::*; #(
  parameter int BUCKET_BITS = 15,
  parameter int CAPACITY    = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [KEY_W-1:0]   doc_key,
  input  logic [SCORE_W-1:0] add_score,
  input  logic [CNT_W-1:0]   add_hits,
  input  logic [CNT_W-1:0]   add_real_hits,
  input  logic               add_counts,
  input  logic [IDX_W-1:0]   read_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic               dropped,
  output logic [IDX_W-1:0]   entry_index,
  output logic [KEY_W-1:0]   entry_key,
  output logic [SCORE_W-1:0] entry_score,
  output logic [CNT_W-1:0]   entry_hits,
  output logic [CNT_W-1:0]   entry_real_hits
);

  logic [LIM_W-1:0] entry_limit;
  hra_cmd_t cmd;
  hra_sts_t sts;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) entry_limit <= LIMIT_RESET;
    else if (psel && penable && pwrite && paddr == 2'd0)
      entry_limit <= pwdata[LIM_W-1:0];
  end
  assign prdata = (paddr == 2'd0) ? {{(32-LIM_W){1'b0}}, entry_limit} : 32'd0;

  hra_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_stall, .sts, .cmd
  );

  hra_dp #(.BUCKET_BITS(BUCKET_BITS), .CAPACITY(CAPACITY)) u_dp (
    .clk, .rst, .cmd, .sts, .entry_limit,
    .operation, .doc_key, .add_score, .add_hits, .add_real_hits,
    .add_counts, .read_index,
    .found, .dropped, .entry_index, .entry_key, .entry_score,
    .entry_hits, .entry_real_hits, .res_valid(out_valid)
  );

  // a dropped item never reports as found
  a_drop_nf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && dropped)) else $error("found and dropped");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entry_index))
    else $error("result changed under stall");

  // no item taken while a new result is still to be formed
  a_one: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("second item taken");

endmodule

FILE: hdl/hra_ctrl.sv
// hashed result accumulator: sequencer for lookup, merge, insert and read
// depends on hra_pkg
module hra_ctrl import hra_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_stall,
  input  hra_sts_t sts,
  output hra_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_HEAD  = 8'b00000100,
    S_ENT   = 8'b00001000,
    S_CMP   = 8'b00010000,
    S_RD    = 8'b00100000,
    S_RCMP  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // item taken only when idle and result slot empty or leaving
  assign in_stall = (state != S_IDLE) || (sts.out_valid && out_stall);

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.out_take = sts.out_valid && !out_stall;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        unique case (sts.op)
          OP_ADD, OP_PROBE: begin
            cmd.head_rd = 1'b1;
            state_next = S_ENT;
          end
          OP_READ: begin
            cmd.rd_idx = 1'b1;
            state_next = S_RD;
          end
          default: begin
            cmd.fin_miss = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_ENT: begin
        if (!sts.head_valid || !sts.ptr_ok) state_next = S_DONE;
        else begin
          cmd.ent_rd = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.key_match) begin
          cmd.upd = 1'b1;
          cmd.fin_hit = 1'b1;
          state_next = S_IDLE;
        end else if (sts.next_valid) begin
          cmd.follow = 1'b1;
          state_next = S_ENT;
        end else state_next = S_DONE;
      end
      S_DONE: begin
        // key not in table
        state_next = S_IDLE;
        if (sts.op == OP_ADD) begin
          if (sts.full) cmd.fin_drop = 1'b1;
          else begin
            cmd.ins = 1'b1;
            cmd.fin_hit = 1'b1;
          end
        end else cmd.fin_miss = 1'b1;
      end
      S_RD: begin
        if (sts.ridx_ok) begin
          cmd.ent_rd = 1'b1;
          state_next = S_RCMP;
        end else begin
          cmd.fin_miss = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RCMP: begin
        cmd.fin_hit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

FILE: hdl/hra_dp.sv
// hashed result accumulator: bucket and entry memories, merge arithmetic,
// result register; depends on hra_pkg
module hra_dp import hra_pkg::*; #(
  parameter int BUCKET_BITS = 15,
  parameter int CAPACITY    = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hra_cmd_t             cmd,
  output hra_sts_t             sts,
  input  logic [LIM_W-1:0]     entry_limit,
  input  logic [1:0]           operation,
  input  logic [KEY_W-1:0]     doc_key,
  input  logic [SCORE_W-1:0]   add_score,
  input  logic [CNT_W-1:0]     add_hits,
  input  logic [CNT_W-1:0]     add_real_hits,
  input  logic                 add_counts,
  input  logic [IDX_W-1:0]     read_index,
  output logic                 found,
  output logic                 dropped,
  output logic [IDX_W-1:0]     entry_index,
  output logic [KEY_W-1:0]     entry_key,
  output logic [SCORE_W-1:0]   entry_score,
  output logic [CNT_W-1:0]     entry_hits,
  output logic [CNT_W-1:0]     entry_real_hits,
  output logic                 res_valid
);

  localparam int NB  = 1 << BUCKET_BITS;
  localparam int PW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int HW  = PW + 1;   // head: valid bit and pointer
  localparam int EW  = KEY_W + SCORE_W + 2 * CNT_W + PW + 1;

  logic [HW-1:0] head_mem [NB];
  logic [EW-1:0] ent_mem [CAPACITY];

  logic [1:0]             op_r;
  logic [KEY_W-1:0]       key_r;
  logic [SCORE_W-1:0]     score_r;
  logic [CNT_W-1:0]       hits_r, rhits_r;
  logic                   addc_r;
  logic [IDX_W-1:0]       ridx_r;
  logic [CW-1:0]          count;
  logic [PW-1:0]          ptr;
  logic [HW-1:0]          head_q;
  logic [EW-1:0]          ent_q;
  logic                   head_ok;
  logic [BUCKET_BITS:0]   clr_addr;
  logic [BUCKET_BITS-1:0] bucket;
  logic                   head_fresh;
  logic [PW-1:0]          ptr_use;

  logic [KEY_W-1:0]   e_key;
  logic [SCORE_W-1:0] e_score;
  logic [CNT_W-1:0]   e_hits, e_rhits;
  logic [PW-1:0]      e_next;
  logic               e_nv;
  assign {e_key, e_score, e_hits, e_rhits, e_next, e_nv} = ent_q;

  assign bucket = key_r[BUCKET_BITS-1:0];

  // merged values
  logic [SCORE_W-1:0] s1, m_score;
  logic [CNT_W-1:0]   m_hits, m_rhits;
  logic               add_all;
  always_comb begin
    add_all = (op_r == OP_PROBE) || addc_r;
    // only an add with counts takes the score twice
    s1      = (op_r == OP_ADD && addc_r) ? sat_score(e_score, score_r) : e_score;
    m_score = (op_r == OP_READ) ? e_score : sat_score(s1, score_r);
    m_hits  = (add_all && op_r != OP_READ) ? sat_cnt(e_hits, hits_r) : e_hits;
    m_rhits = (add_all && op_r != OP_READ) ? sat_cnt(e_rhits, rhits_r) : e_rhits;
  end

  logic [CW-1:0] lim_eff;
  always_comb begin
    if ({{(32-LIM_W){1'b0}}, entry_limit} > CAPACITY) lim_eff = CW'(CAPACITY);
    else lim_eff = CW'(entry_limit);
  end

  // pointer taken from head in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) head_fresh <= 1'b0;
    else head_fresh <= cmd.head_rd;
  end
  always_comb head_ok = 1'b1;

  assign ptr_use = head_fresh ? head_q[PW-1:0] : ptr;

  always_ff @(posedge clk) begin
    if (cmd.clr_step && !clr_addr[BUCKET_BITS])
      head_mem[clr_addr[BUCKET_BITS-1:0]] <= '0;
    else if (cmd.ins)
      head_mem[bucket] <= {1'b1, count[PW-1:0]};
    if (cmd.head_rd) head_q <= head_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (cmd.upd)
      ent_mem[ptr] <= {e_key, m_score, m_hits, m_rhits, e_next, e_nv};
    else if (cmd.ins)
      ent_mem[count[PW-1:0]] <= {key_r, score_r, hits_r, rhits_r,
                                 head_q[PW-1:0], head_q[PW]};
    if (cmd.ent_rd) ent_q <= ent_mem[ptr_use];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= operation; key_r <= doc_key; score_r <= add_score;
      hits_r <= add_hits; rhits_r <= add_real_hits; addc_r <= add_counts;
      ridx_r <= read_index;
    end
    if (head_fresh) ptr <= head_q[PW-1:0];
    else if (cmd.follow) ptr <= e_next;
    else if (cmd.rd_idx) ptr <= PW'(ridx_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_step && !clr_addr[BUCKET_BITS]) clr_addr <= clr_addr + 1'b1;
      if (cmd.ins) count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (cmd.fin_hit || cmd.fin_miss || cmd.fin_drop) res_valid <= 1'b1;
    else if (cmd.out_take) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_hit && cmd.ins) begin
      found <= 1'b0; dropped <= 1'b0;
      entry_index <= IDX_W'(count);
      entry_key <= key_r; entry_score <= score_r;
      entry_hits <= hits_r; entry_real_hits <= rhits_r;
    end else if (cmd.fin_hit) begin
      found <= 1'b1; dropped <= 1'b0;
      entry_index <= IDX_W'(ptr);
      entry_key <= e_key; entry_score <= m_score;
      entry_hits <= m_hits; entry_real_hits <= m_rhits;
    end else if (cmd.fin_miss || cmd.fin_drop) begin
      found <= 1'b0; dropped <= cmd.fin_drop;
      entry_index <= '0; entry_key <= '0; entry_score <= '0;
      entry_hits <= '0; entry_real_hits <= '0;
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.head_valid = head_fresh ? head_q[PW] : 1'b1;
    sts.key_match  = (e_key == key_r) && head_ok;
    sts.next_valid = e_nv;
    sts.ptr_ok     = {1'b0, ptr_use} < count;
    sts.full       = (count >= lim_eff);
    sts.ridx_ok    = {{(CW > IDX_W ? CW - IDX_W : 0){1'b0}}, ridx_r} < count;
    sts.clr_done   = clr_addr[BUCKET_BITS];
    sts.out_valid  = res_valid;
  end

endmodule

FILE: sim/testbench.sv
// testbench for hashed_result_accumulator_core: directed table, then random
// phases at several entry limits, checked against an in-bench predictor or the
// expectation typed in the table; depends on hra_pkg and the hashed_result_accumulator_core rtl
module testbench;
  import hra_pkg::*;

  localparam logic [1:0] OP_NONE         = 2'd3;
  localparam logic [1:0] REG_ENTRY_LIMIT = 2'd0;
  localparam int         NUM_HEADS       = 32768;
  localparam int         NUM_SLOTS       = 4096;

  typedef struct packed {
    logic [1:0]         op;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   rhits;
    logic               addc;
    logic [IDX_W-1:0]   ridx;
  } item_t;

  typedef struct packed {
    logic               found;
    logic               dropped;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   rhits;
  } result_t;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } row_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [1:0] operation = '0;
  logic [KEY_W-1:0] doc_key = '0;
  logic [SCORE_W-1:0] add_score = '0;
  logic [CNT_W-1:0] add_hits = '0, add_real_hits = '0;
  logic add_counts = 0;
  logic [IDX_W-1:0] read_index = '0;
  logic found, dropped;
  logic [IDX_W-1:0] entry_index;
  logic [KEY_W-1:0] entry_key;
  logic [SCORE_W-1:0] entry_score;
  logic [CNT_W-1:0] entry_hits, entry_real_hits;

  // typed expectation travels with the item it belongs to
  logic typed_on = 0;
  result_t typed_res = '0;

  hashed_result_accumulator_core u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .operation, .doc_key, .add_score, .add_hits,
    .add_real_hits, .add_counts, .read_index, .out_valid, .out_stall,
    .found, .dropped, .entry_index, .entry_key, .entry_score, .entry_hits,
    .entry_real_hits
  );

  always #4 clk = ~clk;

  // shadow store
  logic [12:0]        head_ptr [NUM_HEADS];
  bit                 head_ok  [NUM_HEADS];
  logic [KEY_W-1:0]   slot_key [NUM_SLOTS];
  logic [12:0]        slot_next[NUM_SLOTS];
  bit                 next_ok  [NUM_SLOTS];
  logic [SCORE_W-1:0] slot_score[NUM_SLOTS];
  logic [CNT_W-1:0]   slot_hits [NUM_SLOTS];
  logic [CNT_W-1:0]   slot_rhits[NUM_SLOTS];
  int unsigned        slot_count = 0;
  int unsigned        limit_reg = 4096;

  result_t pending_results[$];
  logic [KEY_W-1:0] stored_keys[$];
  int errors = 0;
  int idle_pct = 23;
  bit hold_go = 0;

  function automatic logic [SCORE_W-1:0] score_sum(logic [SCORE_W-1:0] a, logic [SCORE_W-1:0] b);
    logic [SCORE_W:0] s;
    s = a + b;
    return s[SCORE_W] ? '1 : s[SCORE_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] count_sum(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = a + b;
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  function automatic int chain_search(logic [KEY_W-1:0] key);
    int unsigned h, p;
    h = key[14:0];
    if (!head_ok[h]) return -1;
    p = head_ptr[h];
    for (int unsigned n = 0; n < slot_count; n++) begin
      if (p >= slot_count) return -1;
      if (slot_key[p] == key) return p;
      if (!next_ok[p]) return -1;
      p = slot_next[p];
    end
    return -1;
  endfunction

  function automatic result_t slot_view(int unsigned p, logic hit);
    result_t r;
    r = '{found: hit, dropped: 1'b0, idx: p[IDX_W-1:0], key: slot_key[p],
          score: slot_score[p], hits: slot_hits[p], rhits: slot_rhits[p]};
    return r;
  endfunction

  function automatic result_t accumulate(item_t it);
    result_t r;
    int pos;
    int unsigned cap, h;
    r = '0;
    case (it.op)
      OP_ADD: begin
        pos = chain_search(it.key);
        if (pos >= 0) begin
          if (it.addc) begin
            slot_score[pos] = score_sum(slot_score[pos], it.score);
            slot_hits[pos]  = count_sum(slot_hits[pos], it.hits);
            slot_rhits[pos] = count_sum(slot_rhits[pos], it.rhits);
          end
          slot_score[pos] = score_sum(slot_score[pos], it.score);
          r = slot_view(pos, 1'b1);
        end else begin
          cap = limit_reg > NUM_SLOTS ? NUM_SLOTS : limit_reg;
          if (slot_count >= cap) begin
            r.dropped = 1'b1;
          end else begin
            h = it.key[14:0];
            slot_key[slot_count]   = it.key;
            slot_score[slot_count] = it.score;
            slot_hits[slot_count]  = it.hits;
            slot_rhits[slot_count] = it.rhits;
            slot_next[slot_count]  = head_ptr[h];
            next_ok[slot_count]    = head_ok[h];
            head_ptr[h] = 13'(slot_count);
            head_ok[h]  = 1'b1;
            stored_keys.push_back(it.key);
            r = slot_view(slot_count, 1'b0);
            slot_count++;
          end
        end
      end
      OP_PROBE: begin
        pos = chain_search(it.key);
        if (pos >= 0) begin
          slot_hits[pos]  = count_sum(slot_hits[pos], it.hits);
          slot_rhits[pos] = count_sum(slot_rhits[pos], it.rhits);
          slot_score[pos] = score_sum(slot_score[pos], it.score);
          r = slot_view(pos, 1'b1);
        end
      end
      OP_READ: begin
        if (it.ridx < slot_count) r = slot_view(it.ridx, 1'b1);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic field_check(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // accept side and result side, both sampled at the edge
  always @(posedge clk) begin
    result_t want, pred;
    if (!rst && in_valid && !in_stall) begin
      pred = accumulate('{operation, doc_key, add_score, add_hits, add_real_hits,
                          add_counts, read_index});
      pending_results.push_back(typed_on ? typed_res : pred);
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result item with nothing expected", $time);
      end else begin
        want = pending_results.pop_front();
        field_check("found", want.found, found);
        field_check("dropped", want.dropped, dropped);
        field_check("entry_index", want.idx, entry_index);
        field_check("entry_key", want.key, entry_key);
        field_check("entry_score", want.score, entry_score);
        field_check("entry_hits", want.hits, entry_hits);
        field_check("entry_real_hits", want.rhits, entry_real_hits);
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic send_item(item_t it, bit typed, result_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= it.op;
    doc_key       <= it.key;
    add_score     <= it.score;
    add_hits      <= it.hits;
    add_real_hits <= it.rhits;
    add_counts    <= it.addc;
    read_index    <= it.ridx;
    typed_on      <= typed;
    typed_res     <= res;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    // let the accepting edge pass first so the last accepted item is already queued
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(int unsigned value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= REG_ENTRY_LIMIT; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    limit_reg = value & 32'h1FFF;
  endtask

  function automatic item_t random_item();
    item_t it;
    int unsigned r;
    r = $urandom_range(99);
    it.op = r < 45 ? OP_ADD : r < 75 ? OP_PROBE : r < 95 ? OP_READ : OP_NONE;
    r = $urandom_range(99);
    if (stored_keys.size() != 0 && r < 60) begin
      it.key = stored_keys[$urandom_range(stored_keys.size() - 1)];
    end else if (r < 85) begin
      // few buckets so chains grow long
      it.key = {16'($urandom_range(16'hFFFF)), 15'($urandom_range(7) * 1021)};
    end else begin
      it.key = KEY_W'($urandom);
    end
    it.score = $urandom_range(7) == 0 ? 32'hFFFF0000 | $urandom : $urandom;
    it.hits  = $urandom_range(3) == 0 ? CNT_W'($urandom) : CNT_W'($urandom_range(1000));
    it.rhits = $urandom_range(3) == 0 ? CNT_W'($urandom) : CNT_W'($urandom_range(1000));
    it.addc  = 1'($urandom_range(1));
    it.ridx  = $urandom_range(4) == 0 ? IDX_W'($urandom)
                                      : IDX_W'($urandom_range(slot_count + 1));
    return it;
  endfunction

  task automatic random_phase(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(random_item(), 1'b0, '0);
  endtask

  row_t rows[$];

  initial begin
    localparam logic [KEY_W-1:0] KMAX = '1;
    rows = '{
      '{'{OP_READ, 31'd0, 32'd0, 24'd0, 24'd0, 1'b0, 12'd0}, 1, '0},
      '{'{OP_READ, 31'd0, 32'd0, 24'd0, 24'd0, 1'b0, 12'hFFF}, 1, '0},
      '{'{OP_PROBE, 31'd5, 32'd7, 24'd1, 24'd1, 1'b0, 12'd0}, 1, '0},
      '{'{OP_ADD, 31'd5, 32'h10000, 24'd1, 24'd2, 1'b0, 12'd0}, 1,
        '{1'b0, 1'b0, 12'd0, 31'd5, 32'h10000, 24'd1, 24'd2}},
      '{'{OP_ADD, 31'd32773, 32'h28000, 24'd3, 24'd4, 1'b1, 12'd0}, 0, '0},
      '{'{OP_ADD, KMAX, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 12'hFFF}, 1,
        '{1'b0, 1'b0, 12'd2, KMAX, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF}},
      '{'{OP_ADD, 31'd9, 32'd1, 24'd1, 24'd1, 1'b0, 12'd0}, 1,
        '{1'b0, 1'b1, 12'd0, 31'd0, 32'd0, 24'd0, 24'd0}},
      '{'{OP_PROBE, 31'd5, 32'h8000, 24'd10, 24'd20, 1'b0, 12'd0}, 0, '0},
      '{'{OP_ADD, 31'd5, 32'h18000, 24'd5, 24'd6, 1'b1, 12'd0}, 0, '0},
      '{'{OP_ADD, 31'd32773, 32'd3, 24'd9, 24'd9, 1'b0, 12'd0}, 0, '0},
      '{'{OP_ADD, KMAX, 32'd1, 24'd1, 24'd1, 1'b1, 12'd0}, 1,
        '{1'b1, 1'b0, 12'd2, KMAX, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF}},
      '{'{OP_PROBE, KMAX, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 12'd0}, 1,
        '{1'b1, 1'b0, 12'd2, KMAX, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF}},
      '{'{OP_READ, 31'd0, 32'd0, 24'd0, 24'd0, 1'b0, 12'd1}, 0, '0},
      '{'{OP_READ, 31'd0, 32'd0, 24'd0, 24'd0, 1'b0, 12'd3}, 1, '0},
      '{'{OP_NONE, KMAX, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 12'hFFF}, 1, '0},
      // same bucket, absent: walks the whole chain
      '{'{OP_PROBE, 31'd65541, 32'd1, 24'd1, 24'd1, 1'b0, 12'd0}, 1, '0},
      '{'{OP_READ, 31'd0, 32'd0, 24'd0, 24'd0, 1'b0, 12'd0}, 0, '0}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_limit(3);
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);
    drain();

    // nothing new may enter
    write_limit(0);
    random_phase(60);
    drain();

    // above capacity; long receiver hold-off and a calm stretch
    write_limit(32'h1FFF);
    hold_go <= 1'b1;
    random_phase(120);
    idle_pct = 0;
    random_phase(60);
    idle_pct = 23;
    drain();

    write_limit(slot_count + 25);
    random_phase(120);
    drain();

    write_limit(4096);
    random_phase(90);
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
